// ===== design/lun_pkg.sv =====
// Shared types, constants and the Newton-step microprogram for the undistortion block.
`timescale 1ns / 1ps
package lun_pkg;

  typedef logic signed [63:0] fx_t;

  // Internal saturation limit and fixed-point constants (Q.28)
  localparam fx_t LIM       = 64'sh0FFF_FFFF_FFFF_FFFF;
  localparam fx_t ONE_Q     = 64'sh0000_0000_1000_0000;
  localparam fx_t TWO_Q     = 64'sh0000_0000_2000_0000;
  localparam fx_t THREE_Q   = 64'sh0000_0000_3000_0000;
  localparam fx_t SIX_Q     = 64'sh0000_0000_6000_0000;
  localparam fx_t STOP_Q    = 64'sd26844;

  // Register file depth and operand sources
  localparam int RF_DEPTH = 24;
  localparam logic [4:0] R_U     = 5'd0;
  localparam logic [4:0] R_V     = 5'd1;
  localparam logic [4:0] R_X     = 5'd2;
  localparam logic [4:0] R_Y     = 5'd3;
  localparam logic [4:0] SRC_K1  = 5'd24;
  localparam logic [4:0] SRC_K2  = 5'd25;
  localparam logic [4:0] SRC_P1  = 5'd26;
  localparam logic [4:0] SRC_P2  = 5'd27;
  localparam logic [4:0] SRC_ONE = 5'd28;
  localparam logic [4:0] SRC_TWO = 5'd29;
  localparam logic [4:0] SRC_THR = 5'd30;
  localparam logic [4:0] SRC_SIX = 5'd31;

  // Micro-op codes
  localparam logic [2:0] OP_MUL = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_RCP = 3'd3;
  localparam logic [2:0] OP_CHK = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] CFG_CENTER_X = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y = 3'd3;
  localparam logic [2:0] CFG_K1       = 3'd4;
  localparam logic [2:0] CFG_K2       = 3'd5;
  localparam logic [2:0] CFG_P1       = 3'd6;
  localparam logic [2:0] CFG_P2       = 3'd7;

  localparam int PROG_LEN = 68;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] dst;
    logic [4:0] a;
    logic [4:0] b;
  } uop_t;

  // Saturating add at the internal limit
  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic signed [64:0] s;
    logic signed [64:0] lim_w;
    lim_w = {LIM[63], LIM};
    s = {a[63], a} + {b[63], b};
    if (s > lim_w) return LIM;
    if (s < -lim_w) return -LIM;
    return s[63:0];
  endfunction

  function automatic uop_t mk(input logic [2:0] op, input logic [4:0] dst,
                              input logic [4:0] a, input logic [4:0] b);
    uop_t u;
    u.op = op; u.dst = dst; u.a = a; u.b = b;
    return u;
  endfunction

  // One Newton step: Jacobian, residual, Cramer solve, update, stop test
  function automatic uop_t prog(input logic [6:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = mk(OP_MUL, 5'd4,  R_X,     R_X);
      7'd1:  u = mk(OP_MUL, 5'd5,  R_Y,     R_Y);
      7'd2:  u = mk(OP_MUL, 5'd6,  R_X,     R_Y);
      7'd3:  u = mk(OP_ADD, 5'd7,  5'd4,    5'd5);
      7'd4:  u = mk(OP_MUL, 5'd8,  SRC_K2,  5'd7);
      7'd5:  u = mk(OP_ADD, 5'd8,  SRC_K1,  5'd8);
      7'd6:  u = mk(OP_MUL, 5'd8,  5'd7,    5'd8);
      7'd7:  u = mk(OP_ADD, 5'd9,  SRC_ONE, 5'd8);
      7'd8:  u = mk(OP_MUL, 5'd10, SRC_K2,  5'd7);
      7'd9:  u = mk(OP_MUL, 5'd10, 5'd10,   SRC_TWO);
      7'd10: u = mk(OP_ADD, 5'd10, SRC_K1,  5'd10);
      7'd11: u = mk(OP_MUL, 5'd10, 5'd10,   SRC_TWO);
      7'd12: u = mk(OP_MUL, 5'd11, SRC_P1,  R_X);
      7'd13: u = mk(OP_MUL, 5'd12, SRC_P1,  R_Y);
      7'd14: u = mk(OP_MUL, 5'd13, SRC_P2,  R_X);
      7'd15: u = mk(OP_MUL, 5'd14, SRC_P2,  R_Y);
      7'd16: u = mk(OP_MUL, 5'd15, 5'd4,    5'd10);
      7'd17: u = mk(OP_ADD, 5'd15, 5'd9,    5'd15);
      7'd18: u = mk(OP_MUL, 5'd16, 5'd12,   SRC_TWO);
      7'd19: u = mk(OP_MUL, 5'd17, 5'd13,   SRC_SIX);
      7'd20: u = mk(OP_ADD, 5'd16, 5'd16,   5'd17);
      7'd21: u = mk(OP_ADD, 5'd15, 5'd15,   5'd16);
      7'd22: u = mk(OP_MUL, 5'd16, 5'd5,    5'd10);
      7'd23: u = mk(OP_ADD, 5'd16, 5'd9,    5'd16);
      7'd24: u = mk(OP_MUL, 5'd17, 5'd13,   SRC_TWO);
      7'd25: u = mk(OP_MUL, 5'd18, 5'd12,   SRC_SIX);
      7'd26: u = mk(OP_ADD, 5'd17, 5'd17,   5'd18);
      7'd27: u = mk(OP_ADD, 5'd16, 5'd16,   5'd17);
      7'd28: u = mk(OP_MUL, 5'd17, 5'd6,    5'd10);
      7'd29: u = mk(OP_ADD, 5'd18, 5'd11,   5'd14);
      7'd30: u = mk(OP_MUL, 5'd18, 5'd18,   SRC_TWO);
      7'd31: u = mk(OP_ADD, 5'd17, 5'd17,   5'd18);
      7'd32: u = mk(OP_MUL, 5'd18, 5'd15,   5'd16);
      7'd33: u = mk(OP_MUL, 5'd19, 5'd17,   5'd17);
      7'd34: u = mk(OP_SUB, 5'd18, 5'd18,   5'd19);
      7'd35: u = mk(OP_MUL, 5'd19, R_X,     5'd9);
      7'd36: u = mk(OP_MUL, 5'd20, SRC_P1,  5'd6);
      7'd37: u = mk(OP_MUL, 5'd20, 5'd20,   SRC_TWO);
      7'd38: u = mk(OP_ADD, 5'd19, 5'd19,   5'd20);
      7'd39: u = mk(OP_MUL, 5'd20, 5'd4,    SRC_THR);
      7'd40: u = mk(OP_ADD, 5'd20, 5'd20,   5'd5);
      7'd41: u = mk(OP_MUL, 5'd20, SRC_P2,  5'd20);
      7'd42: u = mk(OP_ADD, 5'd19, 5'd19,   5'd20);
      7'd43: u = mk(OP_MUL, 5'd20, R_Y,     5'd9);
      7'd44: u = mk(OP_MUL, 5'd21, SRC_P2,  5'd6);
      7'd45: u = mk(OP_MUL, 5'd21, 5'd21,   SRC_TWO);
      7'd46: u = mk(OP_ADD, 5'd20, 5'd20,   5'd21);
      7'd47: u = mk(OP_MUL, 5'd21, 5'd5,    SRC_THR);
      7'd48: u = mk(OP_ADD, 5'd21, 5'd4,    5'd21);
      7'd49: u = mk(OP_MUL, 5'd21, SRC_P1,  5'd21);
      7'd50: u = mk(OP_ADD, 5'd20, 5'd20,   5'd21);
      7'd51: u = mk(OP_SUB, 5'd19, R_U,     5'd19);
      7'd52: u = mk(OP_SUB, 5'd20, R_V,     5'd20);
      7'd53: u = mk(OP_RCP, 5'd18, 5'd18,   5'd18);
      7'd54: u = mk(OP_MUL, 5'd21, 5'd16,   5'd19);
      7'd55: u = mk(OP_MUL, 5'd22, 5'd17,   5'd20);
      7'd56: u = mk(OP_SUB, 5'd21, 5'd21,   5'd22);
      7'd57: u = mk(OP_MUL, 5'd21, 5'd21,   5'd18);
      7'd58: u = mk(OP_MUL, 5'd22, 5'd15,   5'd20);
      7'd59: u = mk(OP_MUL, 5'd23, 5'd17,   5'd19);
      7'd60: u = mk(OP_SUB, 5'd22, 5'd22,   5'd23);
      7'd61: u = mk(OP_MUL, 5'd22, 5'd22,   5'd18);
      7'd62: u = mk(OP_ADD, R_X,   R_X,     5'd21);
      7'd63: u = mk(OP_ADD, R_Y,   R_Y,     5'd22);
      7'd64: u = mk(OP_MUL, 5'd4,  5'd21,   5'd21);
      7'd65: u = mk(OP_MUL, 5'd5,  5'd22,   5'd22);
      7'd66: u = mk(OP_ADD, 5'd4,  5'd4,    5'd5);
      default: u = mk(OP_CHK, 5'd4, 5'd4,   5'd4);
    endcase
    return u;
  endfunction

endpackage

// ===== design/lens_undistort_newton_top.sv =====
// Lens undistortion top level: config registers, sequencer, register file, output word.
// Each word is normalized and loaded, then runs Newton steps (multiplies on the shared
// 4-pass multiplier, adds, the reciprocal on the bit-serial divider, the stop test) and
// is delivered; at most MAX_ITERATIONS steps. One word is in flight at a time; input
// stalls until the result is written to the output register. Synchronous reset clears
// the control regs and loads the config regs with their defaults.
`timescale 1ns / 1ps
module lens_undistort_newton_top #(
  parameter int MAX_ITERATIONS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        pixel_u,
  input  logic [15:0]        pixel_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] norm_x,
  output logic signed [31:0] norm_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import lun_pkg::*;

  localparam int IW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DU   = 4'd1;
  localparam logic [3:0] S_DUW  = 4'd2;
  localparam logic [3:0] S_WU2  = 4'd3;
  localparam logic [3:0] S_DV   = 4'd4;
  localparam logic [3:0] S_DVW  = 4'd5;
  localparam logic [3:0] S_WV2  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_EX   = 4'd8;
  localparam logic [3:0] S_MW   = 4'd9;
  localparam logic [3:0] S_DW   = 4'd10;
  localparam logic [3:0] S_FRD  = 4'd11;
  localparam logic [3:0] S_FOUT = 4'd12;

  // Configuration registers
  logic [15:0]        focal_x, focal_y, center_x, center_y;
  logic signed [31:0] radial_k1, radial_k2, tangential_p1, tangential_p2;

  logic [3:0]    state;
  logic [6:0]    pc;
  logic [IW-1:0] iter_cnt;
  logic [15:0]   pix_u, pix_v;
  fx_t           nq_hold;
  logic          div_neg;

  fx_t           rf [RF_DEPTH];
  fx_t           rd_a, rd_b;
  logic [4:0]    ra, rb, wa;
  logic          we;
  fx_t           wd;

  uop_t          uop;
  fx_t           oa, ob, sum_r, dif_r;
  logic          mul_start, mul_done, div_start, div_done;
  fx_t           mul_prod;
  logic [56:0]   div_num, div_quo;
  logic [60:0]   div_den;
  fx_t           quo_s;
  logic signed [16:0] diff_u, diff_v;
  logic [15:0]   mag_u, mag_v, den_x, den_y;
  logic [63:0]   abs_oa;
  logic          stop_hit, last_iter, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign uop       = prog(pc);
  assign out_free  = !out_valid || !out_stall;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x       <= 16'd8192;
      focal_y       <= 16'd8192;
      center_x      <= 16'd5120;
      center_y      <= 16'd3840;
      radial_k1     <= '0;
      radial_k2     <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FOCAL_X:  focal_x       <= cfg_data[15:0];
        CFG_FOCAL_Y:  focal_y       <= cfg_data[15:0];
        CFG_CENTER_X: center_x      <= cfg_data[15:0];
        CFG_CENTER_Y: center_y      <= cfg_data[15:0];
        CFG_K1:       radial_k1     <= cfg_data;
        CFG_K2:       radial_k2     <= cfg_data;
        CFG_P1:       tangential_p1 <= cfg_data;
        CFG_P2:       tangential_p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand select: register file or constant source
  function automatic fx_t pick(input logic [4:0] src, input fx_t rd,
                               input logic signed [31:0] k1, input logic signed [31:0] k2,
                               input logic signed [31:0] p1, input logic signed [31:0] p2);
    case (src)
      SRC_K1:  return 64'(k1);
      SRC_K2:  return 64'(k2);
      SRC_P1:  return 64'(p1);
      SRC_P2:  return 64'(p2);
      SRC_ONE: return ONE_Q;
      SRC_TWO: return TWO_Q;
      SRC_THR: return THREE_Q;
      SRC_SIX: return SIX_Q;
      default: return rd;
    endcase
  endfunction

  always_comb begin
    oa = pick(uop.a, rd_a, radial_k1, radial_k2, tangential_p1, tangential_p2);
    ob = pick(uop.b, rd_b, radial_k1, radial_k2, tangential_p1, tangential_p2);
    sum_r = sat_add(oa, ob);
    dif_r = sat_add(oa, -ob);
    abs_oa = oa[63] ? 64'(-oa) : 64'(oa);
    stop_hit = (oa < STOP_Q);
    last_iter = (iter_cnt == IW'(MAX_ITERATIONS - 1));
    quo_s = div_neg ? -fx_t'({7'b0, div_quo}) : fx_t'({7'b0, div_quo});
  end

  // Centering, divider operands and multiplier/divider starts
  always_comb begin
    diff_u = $signed({1'b0, pix_u}) - $signed({1'b0, center_x});
    diff_v = $signed({1'b0, pix_v}) - $signed({1'b0, center_y});
    mag_u  = diff_u[16] ? 16'(-diff_u) : diff_u[15:0];
    mag_v  = diff_v[16] ? 16'(-diff_v) : diff_v[15:0];
    den_x  = (focal_x == 16'd0) ? 16'd1 : focal_x;
    den_y  = (focal_y == 16'd0) ? 16'd1 : focal_y;
    div_start = 1'b0;
    div_num   = {13'b0, mag_u, 28'b0};
    div_den   = {45'b0, den_x};
    mul_start = 1'b0;
    case (state)
      S_DU: div_start = 1'b1;
      S_DV: begin
        div_start = 1'b1;
        div_num   = {13'b0, mag_v, 28'b0};
        div_den   = {45'b0, den_y};
      end
      S_EX: begin
        mul_start = (uop.op == OP_MUL);
        div_start = (uop.op == OP_RCP) && (oa != '0);
        div_num   = {1'b1, 56'b0};
        div_den   = abs_oa[60:0];
      end
      default: ;
    endcase
  end

  // Register file read addresses and write port
  always_comb begin
    ra = (uop.a < 5'(RF_DEPTH)) ? uop.a : R_U;
    rb = (uop.b < 5'(RF_DEPTH)) ? uop.b : R_U;
    // Hold the final point on the read ports while the output waits
    if (state == S_FRD || state == S_FOUT) begin
      ra = R_X;
      rb = R_Y;
    end
    we = 1'b0;
    wa = uop.dst;
    wd = mul_prod;
    case (state)
      S_DUW: begin we = div_done; wa = R_U; wd = quo_s; end
      S_WU2: begin we = 1'b1;     wa = R_X; wd = nq_hold; end
      S_DVW: begin we = div_done; wa = R_V; wd = quo_s; end
      S_WV2: begin we = 1'b1;     wa = R_Y; wd = nq_hold; end
      S_EX: begin
        we = (uop.op == OP_ADD) || (uop.op == OP_SUB) ||
             ((uop.op == OP_RCP) && (oa == '0));
        wd = (uop.op == OP_ADD) ? sum_r : (uop.op == OP_SUB) ? dif_r : LIM;
      end
      S_MW: we = mul_done;
      S_DW: begin we = div_done; wd = quo_s; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) rf[wa] <= wd;
    rd_a <= rf[ra];
    rd_b <= rf[rb];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      iter_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FOUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DU;
        S_DU:   state <= S_DUW;
        S_DUW:  if (div_done) state <= S_WU2;
        S_WU2:  state <= S_DV;
        S_DV:   state <= S_DVW;
        S_DVW:  if (div_done) state <= S_WV2;
        S_WV2: begin
          pc       <= '0;
          iter_cnt <= '0;
          state    <= S_RD;
        end
        S_RD:   state <= S_EX;
        S_EX: begin
          unique case (uop.op)
            OP_MUL: state <= S_MW;
            OP_RCP: begin
              if (oa != '0) state <= S_DW;
              else begin
                pc    <= pc + 7'd1;
                state <= S_RD;
              end
            end
            OP_CHK: begin
              if (stop_hit || last_iter) state <= S_FRD;
              else begin
                pc       <= '0;
                iter_cnt <= iter_cnt + IW'(1);
                state    <= S_RD;
              end
            end
            default: begin
              pc    <= pc + 7'd1;
              state <= S_RD;
            end
          endcase
        end
        S_MW: if (mul_done) begin
          pc    <= pc + 7'd1;
          state <= S_RD;
        end
        S_DW: if (div_done) begin
          pc    <= pc + 7'd1;
          state <= S_RD;
        end
        S_FRD: state <= S_FOUT;
        S_FOUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers: input word, quotient sign, held value, output word
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      pix_u <= pixel_u;
      pix_v <= pixel_v;
    end
    if (state == S_DU) div_neg <= diff_u[16];
    if (state == S_DV) div_neg <= diff_v[16];
    if (state == S_EX) div_neg <= oa[63];
    if ((state == S_DUW || state == S_DVW) && div_done) nq_hold <= quo_s;
    if (state == S_FOUT && out_free) begin
      norm_x <= (rd_a > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                (rd_a < -64'sd2147483648) ? 32'sh8000_0000 : rd_a[31:0];
      norm_y <= (rd_b > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                (rd_b < -64'sd2147483648) ? 32'sh8000_0000 : rd_b[31:0];
    end
  end

  lun_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (oa),
    .b     (ob),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lun_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_DU)
    else $error("accepted word did not start normalization");
  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MW)
    else $error("multiplier finished outside its wait state");
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DUW || state == S_DVW || state == S_DW))
    else $error("divider finished outside a wait state");
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state == S_EX |-> pc < 7'(PROG_LEN))
    else $error("micro-op counter past end of program");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == S_FOUT && out_free |=> out_valid && state == S_IDLE)
    else $error("result word not presented");
`endif

endmodule

// ===== design/lun_mul.sv =====
// Shared Q.28 multiplier: four 32x32 partial products, saturated result.
`timescale 1ns / 1ps
module lun_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lun_pkg::fx_t      a,
  input  lun_pkg::fx_t      b,
  output logic              done,
  output lun_pkg::fx_t      prod
);
  import lun_pkg::*;

  logic [59:0]  ma;
  logic [59:0]  mb;
  logic         neg;
  logic [1:0]   cnt;
  logic         busy;
  logic [119:0] acc;
  logic [31:0]  opx;
  logic [31:0]  opy;
  logic [63:0]  pp;
  logic [119:0] pp_sh;
  logic [63:0]  abs_a;
  logic [63:0]  abs_b;
  fx_t          mag_r;

  assign abs_a = a[63] ? 64'(-a) : 64'(a);
  assign abs_b = b[63] ? 64'(-b) : 64'(b);

  // Pick the partial product for this cycle
  always_comb begin
    opx = cnt[0] ? {4'b0, ma[59:32]} : ma[31:0];
    opy = cnt[1] ? {4'b0, mb[59:32]} : mb[31:0];
    pp  = opx * opy;
    case (cnt)
      2'd0:    pp_sh = {56'b0, pp};
      2'd3:    pp_sh = {pp[55:0], 64'b0};
      default: pp_sh = {24'b0, pp, 32'b0};
    endcase
  end

  // Accumulate four partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= busy && (cnt == 2'd3);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= abs_a[59:0];
      mb  <= abs_b[59:0];
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
  end

  // Drop the fraction, saturate, restore sign
  always_comb begin
    if (acc[119:88] != 32'b0) mag_r = LIM;
    else mag_r = {4'b0, acc[87:28]};
    prod = neg ? -mag_r : mag_r;
  end

endmodule

// ===== design/lun_div.sv =====
// Restoring divider, one quotient bit per cycle, 57-bit quotient.
`timescale 1ns / 1ps
module lun_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [56:0] num,
  input  logic [60:0] den,
  output logic        done,
  output logic [56:0] quo
);
  import lun_pkg::*;

  logic [56:0] nsh;
  logic [60:0] dn;
  logic [60:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [61:0] trial;
  logic [61:0] diff;
  logic        ge;

  assign trial = {rem, nsh[56]};
  assign diff  = trial - {1'b0, dn};
  assign ge    = trial >= {1'b0, dn};

  // Sequence the bit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= busy && (cnt == 6'd0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd56;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) busy <= 1'b0;
      end
    end
  end

  // Shift, trial subtract, shift in quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= num;
      dn  <= den;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      nsh <= {nsh[55:0], 1'b0};
      rem <= ge ? diff[60:0] : trial[60:0];
      quo <= {quo[55:0], ge};
    end
  end

endmodule

// ===== bench/lun_checker.sv =====
// Result checker for the lens undistortion block: predicts every word and compares.
`timescale 1ns / 1ps
module lun_checker
  import lun_pkg::*;
#(
  parameter int MAX_ITERATIONS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        pixel_u,
  input  logic [15:0]        pixel_v,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] norm_x,
  input  logic signed [31:0] norm_y,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fails,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  point_t      undistorted_q[$];
  logic [15:0] fl_x, fl_y, pp_x, pp_y;
  fx_t         k1, k2, p1, p2;

  initial begin
    fails   = 0;
    pending = 0;
  end

  function automatic fx_t clip(input fx_t a);
    if (a > LIM) return LIM;
    if (a < -LIM) return -LIM;
    return a;
  endfunction

  function automatic fx_t fadd(input fx_t a, input fx_t b);
    return clip(a + b);
  endfunction

  function automatic fx_t fsub(input fx_t a, input fx_t b);
    return clip(a - b);
  endfunction

  function automatic logic [63:0] fmag(input fx_t a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  // Q.28 product with the magnitude truncated, then saturated
  function automatic fx_t fmul(input fx_t a, input fx_t b);
    logic [127:0] p;
    logic [63:0]  r;
    logic         neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, fmag(a)} * {64'd0, fmag(b)};
    if (p[127:88] != 0) r = LIM;
    else begin
      r = p[91:28];
      if (r > LIM) r = LIM;
    end
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic fx_t frecip(input fx_t d);
    logic [63:0] q;
    if (d == 0) return LIM;
    q = (64'd1 << 56) / fmag(d);
    if (q > LIM) q = LIM;
    return (d < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic fx_t fnorm(input logic [15:0] pix, input logic [15:0] c,
                                input logic [15:0] f);
    fx_t         diff;
    logic [63:0] q;
    diff = $signed({48'd0, pix}) - $signed({48'd0, c});
    q = (fmag(diff) << 28) / ((f == 0) ? 64'd1 : {48'd0, f});
    return (diff < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] to_word(input fx_t a);
    if (a > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (a < -64'sd2147483648) return 32'sh8000_0000;
    return a[31:0];
  endfunction

  // Newton inversion of the radial and tangential distortion
  function automatic point_t undistort(input logic [15:0] pu, input logic [15:0] pv);
    fx_t    u, v, x, y, xx, yy, xy, r2, d, g2, p1x, p1y, p2x, p2y;
    fx_t    j11, j22, j12, det, ex, ey, inv, dx, dy, rx, ry;
    point_t pt;
    u = fnorm(pu, pp_x, fl_x);
    v = fnorm(pv, pp_y, fl_y);
    x = u;
    y = v;
    for (int it = 0; it < MAX_ITERATIONS; it++) begin
      xx  = fmul(x, x);
      yy  = fmul(y, y);
      xy  = fmul(x, y);
      r2  = fadd(xx, yy);
      d   = fadd(ONE_Q, fmul(r2, fadd(k1, fmul(k2, r2))));
      g2  = fmul(fadd(k1, fmul(fmul(k2, r2), TWO_Q)), TWO_Q);
      p1x = fmul(p1, x);
      p1y = fmul(p1, y);
      p2x = fmul(p2, x);
      p2y = fmul(p2, y);
      j11 = fadd(fadd(d, fmul(xx, g2)), fadd(fmul(p1y, TWO_Q), fmul(p2x, SIX_Q)));
      j22 = fadd(fadd(d, fmul(yy, g2)), fadd(fmul(p2x, TWO_Q), fmul(p1y, SIX_Q)));
      j12 = fadd(fmul(xy, g2), fmul(fadd(p1x, p2y), TWO_Q));
      det = fsub(fmul(j11, j22), fmul(j12, j12));
      rx  = fadd(fadd(fmul(x, d), fmul(fmul(p1, xy), TWO_Q)),
                 fmul(p2, fadd(fmul(xx, THREE_Q), yy)));
      ry  = fadd(fadd(fmul(y, d), fmul(fmul(p2, xy), TWO_Q)),
                 fmul(p1, fadd(xx, fmul(yy, THREE_Q))));
      ex  = fsub(u, rx);
      ey  = fsub(v, ry);
      inv = frecip(det);
      dx  = fmul(fsub(fmul(j22, ex), fmul(j12, ey)), inv);
      dy  = fmul(fsub(fmul(j11, ey), fmul(j12, ex)), inv);
      x   = fadd(x, dx);
      y   = fadd(y, dy);
      if (fadd(fmul(dx, dx), fmul(dy, dy)) < STOP_Q) break;
    end
    pt.x = to_word(x);
    pt.y = to_word(y);
    return pt;
  endfunction

  // Track registers, queue predictions, compare delivered words
  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      fl_x <= 16'd8192;
      fl_y <= 16'd8192;
      pp_x <= 16'd5120;
      pp_y <= 16'd3840;
      k1 <= '0;
      k2 <= '0;
      p1 <= '0;
      p2 <= '0;
      undistorted_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FOCAL_X:  fl_x <= cfg_data[15:0];
          CFG_FOCAL_Y:  fl_y <= cfg_data[15:0];
          CFG_CENTER_X: pp_x <= cfg_data[15:0];
          CFG_CENTER_Y: pp_y <= cfg_data[15:0];
          CFG_K1:       k1 <= {{32{cfg_data[31]}}, cfg_data};
          CFG_K2:       k2 <= {{32{cfg_data[31]}}, cfg_data};
          CFG_P1:       p1 <= {{32{cfg_data[31]}}, cfg_data};
          CFG_P2:       p2 <= {{32{cfg_data[31]}}, cfg_data};
          default: ;
        endcase
      end
      if (in_valid && !in_stall) undistorted_q.push_back(undistort(pixel_u, pixel_v));
      if (out_valid && !out_stall) begin
        if (undistorted_q.size() == 0) begin
          if (fails < 10) $display("unexpected word x=%h y=%h", norm_x, norm_y);
          fails <= fails + 1;
        end else begin
          want = undistorted_q.pop_front();
          if (want.x !== norm_x || want.y !== norm_y) begin
            if (fails < 10)
              $display("word mismatch: expected x=%h y=%h, got x=%h y=%h",
                       want.x, want.y, norm_x, norm_y);
            fails <= fails + 1;
          end
        end
      end
    end
    pending <= undistorted_q.size();
  end

endmodule

// ===== bench/tb_lens_undistort_newton_top.sv =====
// Testbench top for the lens undistortion block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_lens_undistort_newton_top;
  import lun_pkg::*;

  localparam int WATCHDOG = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        pixel_u = '0;
  logic [15:0]        pixel_v = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] norm_x, norm_y;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 fails, pending;

  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;
  int          pixels_sent = 0;
  int          settings_used = 0;
  logic [15:0] cur_fx = 16'd8192, cur_fy = 16'd8192, cur_cx = 16'd5120, cur_cy = 16'd3840;

  always #5 clk = ~clk;

  lens_undistort_newton_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_u(pixel_u), .pixel_v(pixel_v),
    .out_valid(out_valid), .out_stall(out_stall), .norm_x(norm_x), .norm_y(norm_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  lun_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_u(pixel_u), .pixel_v(pixel_v),
    .out_valid(out_valid), .out_stall(out_stall), .norm_x(norm_x), .norm_y(norm_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  // Stop the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (4000) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Offer one pixel and hold it until taken, then maybe idle
  task automatic send_pixel(input logic [15:0] u, input logic [15:0] v);
    in_valid <= 1'b1;
    pixel_u  <= u;
    pixel_v  <= v;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load a full register setting while the block is idle
  task automatic load_setting(input logic [15:0] fx, input logic [15:0] fy,
                              input logic [15:0] cx, input logic [15:0] cy,
                              input logic [31:0] rk1, input logic [31:0] rk2,
                              input logic [31:0] tp1, input logic [31:0] tp2);
    drain();
    cfg_write(CFG_FOCAL_X, {16'd0, fx});
    cfg_write(CFG_FOCAL_Y, {16'd0, fy});
    cfg_write(CFG_CENTER_X, {16'd0, cx});
    cfg_write(CFG_CENTER_Y, {16'd0, cy});
    cfg_write(CFG_K1, rk1);
    cfg_write(CFG_K2, rk2);
    cfg_write(CFG_P1, tp1);
    cfg_write(CFG_P2, tp2);
    cfg_valid <= 1'b0;
    cur_fx = fx;
    cur_fy = fy;
    cur_cx = cx;
    cur_cy = cy;
    settings_used++;
  endtask

  function automatic logic [15:0] near(input logic [15:0] c, input logic [15:0] f);
    int p;
    p = int'(c) + int'($urandom_range(0, f)) - int'(f) / 2;
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return p[15:0];
  endfunction

  function automatic logic [31:0] small_coef(input int bits);
    return $signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
  endfunction

  task automatic random_pixels(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) send_pixel(16'($urandom), 16'($urandom));
      else send_pixel(near(cur_cx, cur_fx), near(cur_cy, cur_fy));
      if (i == n / 2 && $urandom_range(0, 3) == 0) drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset setting, field extremes
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd5120, 16'd3840);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'h5555, 16'hAAAA);

    // Directed: singular Jacobian at x = 0.5 with p2 = -1
    load_setting(16'd8192, 16'd8192, 16'd5120, 16'd3840, 32'd0, 32'd0, 32'd0,
                 32'hF000_0000);
    send_pixel(16'd9216, 16'd3840);
    send_pixel(16'd5120, 16'd3840);

    // Directed: zero focal length and saturated results
    load_setting(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd1, 16'd0);
    send_pixel(16'd0, 16'd0);
    load_setting(16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'hFFFE, 16'd1);

    // Directed: moderate barrel distortion
    load_setting(16'd8192, 16'd8192, 16'd5120, 16'd3840, 32'hFC00_0000, 32'h0080_0000,
                 32'h0010_0000, 32'hFFF0_0000);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'd10240, 16'd7680);
    send_pixel(16'd5120, 16'd0);
    send_pixel(16'd6000, 16'd3000);

    // Random phases; the long receiver hold-off lands in the second one
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_setting(16'd8192, 16'd8192, 16'd5120, 16'd3840, small_coef(27),
                        small_coef(25), small_coef(22), small_coef(22));
        1: load_setting(16'($urandom_range(2000, 20000)), 16'($urandom_range(2000, 20000)),
                        16'($urandom), 16'($urandom), small_coef(28), small_coef(26),
                        small_coef(24), small_coef(24));
        2: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: load_setting(16'd1, 16'd1, 16'd0, 16'd0, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000);
        4: load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        $urandom, $urandom, $urandom, $urandom);
        5: load_setting(16'd0, 16'($urandom), 16'($urandom), 16'($urandom),
                        small_coef(30), small_coef(30), small_coef(30), small_coef(30));
        default: load_setting(16'($urandom_range(4000, 12000)),
                              16'($urandom_range(4000, 12000)), 16'($urandom),
                              16'($urandom), small_coef(27), small_coef(25),
                              small_coef(23), small_coef(23));
      endcase
      if (ph == 1) hold_req = 1'b1;
      if (ph == 7) quiet = 1'b1;
      random_pixels(80);
    end

    // Wrap up once every word is back
    in_valid <= 1'b0;
    quiet = 1'b1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Run covered %0d pixels over %0d register settings,", pixels_sent,
             settings_used + 1);
    $display("including singular, zero-focal and saturating cases.");
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lun_pkg.sv
design/lun_mul.sv
design/lun_div.sv
design/lens_undistort_newton_top.sv
bench/lun_checker.sv
bench/tb_lens_undistort_newton_top.sv
